FILE: rtl/blsp_pkg.sv
// Shared constants and types for the bottom-left shape placer.
package blsp_pkg;
   localparam int MaxSide   = 64;
   localparam int MaxCells  = 16;
   localparam int MaxOrient = 8;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;
   localparam logic [1:0] OP_PLACE = 2'd3;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;
endpackage

FILE: rtl/bottom_left_shape_placer.sv
// Top level of the bottom-left shape placer: bitmap memory, shape memory and placement sequencer.
//
//  channel | ports    | direction | content
//  req     | req_t*   | in        | opcode, orient_index, cell_x, cell_y, rotation_tag, flip_tag
//  rsp     | rsp_t*   | out       | placed, place_x, place_y, chosen_rotation, chosen_flip
//  csr     | csr_p*   | in/out    | grid_width at 0x0, grid_height at 0x4
//
// One transaction is worked at a time. Load and start each pass through S_LOAD. Clear sweeps the
// bitmap memory, one row a cycle; the same sweep runs once after reset, while req_tready
// stays low. Place steps through the orientations and tests each candidate origin with
// one cell read and one bitmap row read per shape cell, then writes back one row per
// cell of the chosen orientation. A result waits in its output register; only the next
// result stalls behind it.
module bottom_left_shape_placer #(
   parameter int MAX_SIDE   = blsp_pkg::MaxSide,
   parameter int MAX_CELLS  = blsp_pkg::MaxCells,
   parameter int MAX_ORIENT = blsp_pkg::MaxOrient
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] opcode, [4:2] orient_index, [10:5] cell_x, [16:11] cell_y,
   // [18:17] rotation_tag, [19] flip_tag, [23:20] zero
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] placed, [6:1] place_x, [12:7] place_y, [14:13] chosen_rotation,
   // [15] chosen_flip
   output logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int SW = $clog2(MAX_SIDE);       // coordinate bits
   localparam int CW = $clog2(MAX_SIDE + 1);   // size bits
   localparam int OW = (MAX_ORIENT > 1) ? $clog2(MAX_ORIENT) : 1;
   localparam int KW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int NW = $clog2(MAX_CELLS + 1);
   localparam int XW = SW + 1;                  // sum of origin and offset

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_LOAD  = 4'd2;
   localparam logic [3:0] S_ORNT  = 4'd3;
   localparam logic [3:0] S_CRD   = 4'd4;
   localparam logic [3:0] S_CCHK  = 4'd5;
   localparam logic [3:0] S_MRD   = 4'd6;
   localparam logic [3:0] S_MWR   = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;
   localparam logic [3:0] S_CSRD  = 4'd9;

   // memories
   logic [MAX_SIDE-1:0] bitmap_mem [MAX_SIDE];
   logic [2*SW-1:0]     shape_mem  [MAX_ORIENT * (2 ** KW)];
   logic [MAX_SIDE-1:0] row_rd_ff;
   logic [2*SW-1:0]     cell_rd_ff;

   logic [3:0]    state_ff, state_in;
   logic [6:0]    gw_ff, gh_ff;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic [NW-1:0] cnt_ff [MAX_ORIENT];
   logic [SW-1:0] bx_ff  [MAX_ORIENT];
   logic [SW-1:0] by_ff  [MAX_ORIENT];
   logic [2:0]    tag_ff [MAX_ORIENT];

   logic [23:0]   req_ff;
   logic [OW-1:0] o_ff, o_in;
   logic [SW-1:0] x_ff, x_in, y_ff, y_in;
   logic [KW-1:0] k_ff, k_in;
   logic          found_ff, found_in;
   logic [SW-1:0] bx_best_ff, bx_best_in, by_best_ff, by_best_in;
   logic [OW-1:0] bo_ff, bo_in;
   logic          rsp_valid_ff;
   logic [15:0]   rsp_data_ff;

   logic [CW-1:0] side_w, side_h;
   always_comb begin
      side_w = (int'(gw_ff) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(gw_ff);
      side_h = (int'(gh_ff) > MAX_SIDE) ? CW'(MAX_SIDE) : CW'(gh_ff);
   end

   // request fields
   logic [1:0]    r_op;
   logic [2:0]    r_oi;
   logic [5:0]    r_cx, r_cy;
   assign r_op = req_ff[1:0];
   assign r_oi = req_ff[4:2];
   assign r_cx = req_ff[10:5];
   assign r_cy = req_ff[16:11];

   logic req_fire;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // result register loads once the previous result is gone
   logic rsp_load;
   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   // current orientation info
   logic [CW-1:0] ow_w, ow_h;
   logic          o_usable;
   logic          o_last;
   assign ow_w = CW'(bx_ff[o_ff]) + CW'(1);
   assign ow_h = CW'(by_ff[o_ff]) + CW'(1);
   assign o_usable = (cnt_ff[o_ff] != '0) && (ow_w <= side_w) && (ow_h <= side_h) &&
                     (!found_ff || y_ff <= by_best_ff);
   assign o_last = (o_ff == OW'(MAX_ORIENT - 1));

   // cell position for current origin
   logic [XW-1:0] px, py;
   logic          bit_hit;
   assign px = XW'(x_ff) + XW'(cell_rd_ff[SW-1:0]);
   assign py = XW'(y_ff) + XW'(cell_rd_ff[2*SW-1:SW]);
   assign bit_hit = row_rd_ff[px[SW-1:0]];
   logic          k_last;
   assign k_last = (NW'(k_ff) + NW'(1) >= cnt_ff[o_ff]);
   logic          x_end, y_end;
   assign x_end = (CW'(x_ff) + ow_w >= side_w);
   assign y_end = (CW'(y_ff) + ow_h >= side_h);

   // sub-step within S_CRD/S_CCHK: cell read issued in CRD, row read issued in CCHK phase 0
   logic          ph_ff, ph_in;

   // memory access control
   logic          bm_we;
   logic [SW-1:0] bm_waddr;
   logic [MAX_SIDE-1:0] bm_wdata;
   logic [SW-1:0] bm_raddr;
   logic          sh_we;
   logic [OW+KW-1:0] sh_waddr, sh_raddr;

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      o_in = o_ff; x_in = x_ff; y_in = y_ff; k_in = k_ff; ph_in = ph_ff;
      found_in = found_ff; bx_best_in = bx_best_ff; by_best_in = by_best_ff; bo_in = bo_ff;
      bm_we = 1'b0; bm_waddr = sweep_ff; bm_wdata = '0;
      bm_raddr = py[SW-1:0];
      sh_we = 1'b0;
      sh_waddr = {r_oi[OW-1:0], cnt_ff[r_oi[OW-1:0]][KW-1:0]};
      sh_raddr = {o_ff, k_ff};
      case (state_ff)
         S_INIT, S_CSRD: begin
            bm_we = 1'b1;
            sweep_in = sweep_ff + SW'(1);
            if (sweep_ff == SW'(MAX_SIDE - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_tdata[1:0])
                  blsp_pkg::OP_CLEAR: begin
                     state_in = S_CSRD;
                     sweep_in = '0;
                  end
                  blsp_pkg::OP_PLACE: begin
                     state_in = S_ORNT;
                     o_in = '0;
                     found_in = 1'b0;
                     bx_best_in = '0; by_best_in = '0; bo_in = '0;
                  end
                  default: state_in = S_LOAD;
               endcase
            end
         end
         S_LOAD: begin
            if (r_op == blsp_pkg::OP_LOAD && int'(r_oi) < MAX_ORIENT &&
                cnt_ff[r_oi[OW-1:0]] < NW'(MAX_CELLS))
               sh_we = 1'b1;
            state_in = S_IDLE;
         end
         S_ORNT: begin
            x_in = '0; y_in = '0; k_in = '0; ph_in = 1'b0;
            if (o_usable) state_in = S_CRD;
            else if (o_last) state_in = found_ff ? S_MRD : S_RESP;
            else o_in = o_ff + OW'(1);
            if (!o_usable && o_last) k_in = '0;
            if (!o_usable && o_last) o_in = bo_ff;
            if (!o_usable && o_last) begin
               x_in = bx_best_ff; y_in = by_best_ff;
            end
         end
         S_CRD: begin
            // cell read lands next cycle
            state_in = S_CCHK;
            ph_in = 1'b0;
         end
         S_CCHK: begin
            if (!ph_ff) begin
               ph_in = 1'b1;       // row read of py issued this cycle
            end else begin
               ph_in = 1'b0;
               if (bit_hit) begin
                  k_in = '0;
                  state_in = S_CRD;
                  if (!x_end) x_in = x_ff + SW'(1);
                  else if (!y_end && !(found_ff && y_ff >= by_best_ff)) begin
                     x_in = '0; y_in = y_ff + SW'(1);
                  end else begin
                     state_in = S_ORNT;
                     o_in = o_last ? o_ff : o_ff + OW'(1);
                     if (o_last) state_in = S_ORNT;
                  end
               end else if (!k_last) begin
                  k_in = k_ff + KW'(1);
                  state_in = S_CRD;
               end else begin
                  if (!found_ff || y_ff < by_best_ff ||
                      (y_ff == by_best_ff && x_ff < bx_best_ff)) begin
                     found_in = 1'b1;
                     bx_best_in = x_ff; by_best_in = y_ff; bo_in = o_ff;
                  end
                  state_in = S_ORNT;
                  o_in = o_last ? o_ff : o_ff + OW'(1);
               end
            end
         end
         S_MRD: begin
            // phase 0: read cell; phase 1: read row; then write
            ph_in = !ph_ff;
            if (ph_ff) state_in = S_MWR;
         end
         S_MWR: begin
            bm_we = 1'b1;
            bm_waddr = py[SW-1:0];
            bm_wdata = row_rd_ff;
            bm_wdata[px[SW-1:0]] = 1'b1;
            ph_in = 1'b0;
            if (k_last) state_in = S_RESP;
            else begin
               k_in = k_ff + KW'(1);
               state_in = S_MRD;
            end
         end
         S_RESP: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // a finished scan of the last orientation re-enters S_ORNT with o unchanged; mark it done
   logic          o_done_ff;
   always_ff @(posedge clock) begin
      if (reset) o_done_ff <= 1'b0;
      else if (state_ff == S_IDLE) o_done_ff <= 1'b0;
      else if (state_ff == S_CCHK && state_in == S_ORNT && o_last) o_done_ff <= 1'b1;
   end

   logic [3:0] state_fix;
   logic [OW-1:0] o_fix;
   logic [SW-1:0] x_fix, y_fix;
   always_comb begin
      state_fix = state_in; o_fix = o_in; x_fix = x_in; y_fix = y_in;
      if (state_ff == S_ORNT && o_done_ff) begin
         state_fix = found_ff ? S_MRD : S_RESP;
         o_fix = bo_ff; x_fix = bx_best_ff; y_fix = by_best_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
         gw_ff <= 7'd64;
         gh_ff <= 7'd64;
         for (int i = 0; i < MAX_ORIENT; i++) begin
            cnt_ff[i] <= '0; bx_ff[i] <= '0; by_ff[i] <= '0; tag_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_fix;
         sweep_ff <= sweep_in;
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == blsp_pkg::REG_WIDTH) gw_ff <= csr_pwdata[6:0];
            else gh_ff <= csr_pwdata[6:0];
         end
         if (state_ff == S_LOAD && r_op == blsp_pkg::OP_START) begin
            for (int i = 0; i < MAX_ORIENT; i++) begin
               cnt_ff[i] <= '0; bx_ff[i] <= '0; by_ff[i] <= '0; tag_ff[i] <= '0;
            end
         end
         if (sh_we) begin
            cnt_ff[r_oi[OW-1:0]] <= cnt_ff[r_oi[OW-1:0]] + NW'(1);
            if (SW'(r_cx) > bx_ff[r_oi[OW-1:0]]) bx_ff[r_oi[OW-1:0]] <= SW'(r_cx);
            if (SW'(r_cy) > by_ff[r_oi[OW-1:0]]) by_ff[r_oi[OW-1:0]] <= SW'(r_cy);
            tag_ff[r_oi[OW-1:0]] <= req_ff[19:17];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            if (found_ff)
               rsp_data_ff <= {tag_ff[bo_ff], 6'(by_best_ff), 6'(bx_best_ff), 1'b1};
            else
               rsp_data_ff <= '0;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) req_ff <= req_tdata;
      o_ff <= o_fix; x_ff <= x_fix; y_ff <= y_fix; k_ff <= k_in; ph_ff <= ph_in;
      found_ff <= found_in; bx_best_ff <= bx_best_in; by_best_ff <= by_best_in; bo_ff <= bo_in;
   end

   // bitmap memory
   always_ff @(posedge clock) begin
      if (bm_we) bitmap_mem[bm_waddr] <= bm_wdata;
      row_rd_ff <= bitmap_mem[bm_raddr];
   end

   // shape memory
   always_ff @(posedge clock) begin
      if (sh_we) shape_mem[sh_waddr] <= {SW'(r_cy), SW'(r_cx)};
      cell_rd_ff <= shape_mem[sh_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == blsp_pkg::REG_WIDTH) ? {25'd0, gw_ff} : {25'd0, gh_ff};
endmodule

FILE: rtl/blsp_checker.sv
// Port-level checks for the bottom-left shape placer, bound to the top level.
module blsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   // a failed placement reports all fields zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata == 16'd0) else $error("fail not zero");
   // a result is held until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("result dropped");
   // ready drops right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");
endmodule

bind bottom_left_shape_placer blsp_checker u_blsp_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));

FILE: tb/tb_top.sv
// Self-checking testbench for the bottom-left shape placer.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [3:0] pad;
      logic       flip;
      logic [1:0] rot;
      logic [5:0] cy;
      logic [5:0] cx;
      logic [2:0] oi;
      logic [1:0] op;
   } shape_cmd_type;

   typedef struct packed {
      logic       flip;
      logic [1:0] rot;
      logic [5:0] py;
      logic [5:0] px;
      logic       placed;
   } placement_type;

   typedef struct {
      logic [1:0] op;
      int         oi, cx, cy, rot, flip;
      bit         typed;
      placement_type want;
   } directed_row_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [23:0] req_tdata;   // [1:0] opcode, [4:2] orient, [10:5] x, [16:11] y, [18:17] rot, [19] flip
   logic        rsp_tvalid, rsp_tready;
   logic [15:0] rsp_tdata;   // [0] placed, [6:1] x, [12:7] y, [14:13] rot, [15] flip
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   bottom_left_shape_placer u_dut (.*);

   // shadow state of the placer
   bit         occ [blsp_pkg::MaxSide][blsp_pkg::MaxSide];
   logic [5:0] cell_x [blsp_pkg::MaxOrient][blsp_pkg::MaxCells];
   logic [5:0] cell_y [blsp_pkg::MaxOrient][blsp_pkg::MaxCells];
   int         cell_cnt [blsp_pkg::MaxOrient];
   int         box_x [blsp_pkg::MaxOrient], box_y [blsp_pkg::MaxOrient];
   logic [1:0] tag_rot [blsp_pkg::MaxOrient];
   logic       tag_flip [blsp_pkg::MaxOrient];
   int         grid_w = 64, grid_h = 64;

   placement_type expected_placements [$];
   int         fail_count = 0;
   int         items_sent = 0;
   bit         calm_send, calm_recv;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1s;
      $display("bottom_left_shape_placer test failed");
      $finish;
   end

   task automatic report_mismatch(string what, int want, int got);
      $display("MISMATCH %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      fail_count++;
   endtask

   function automatic void new_piece();
      for (int o = 0; o < blsp_pkg::MaxOrient; o++) begin
         cell_cnt[o] = 0; box_x[o] = 0; box_y[o] = 0;
         tag_rot[o] = 0; tag_flip[o] = 0;
      end
   endfunction

   function automatic bit spot_free(int o, int x, int y);
      for (int c = 0; c < cell_cnt[o]; c++)
         if (occ[y + cell_y[o][c]][x + cell_x[o][c]]) return 0;
      return 1;
   endfunction

   function automatic placement_type place_piece();
      int W, H, bw, bh, bx, by, bo;
      bit found, hit;
      placement_type r;
      W = grid_w > blsp_pkg::MaxSide ? blsp_pkg::MaxSide : grid_w;
      H = grid_h > blsp_pkg::MaxSide ? blsp_pkg::MaxSide : grid_h;
      found = 0; bx = 0; by = 0; bo = 0; r = '0;
      for (int o = 0; o < blsp_pkg::MaxOrient; o++) begin
         bw = box_x[o] + 1;
         bh = box_y[o] + 1;
         if (cell_cnt[o] == 0 || bw > W || bh > H) continue;
         hit = 0;
         for (int y = 0; y + bh <= H && !hit; y++)
            for (int x = 0; x + bw <= W && !hit; x++)
               if (spot_free(o, x, y)) begin
                  hit = 1;
                  if (!found || y < by || (y == by && x < bx)) begin
                     found = 1; bx = x; by = y; bo = o;
                  end
               end
      end
      if (!found) return r;
      for (int c = 0; c < cell_cnt[bo]; c++)
         occ[by + cell_y[bo][c]][bx + cell_x[bo][c]] = 1;
      r.placed = 1;
      r.px = 6'(bx);
      r.py = 6'(by);
      r.rot = tag_rot[bo];
      r.flip = tag_flip[bo];
      return r;
   endfunction

   // updates the shadow state; returns 1 with a placement for a place command
   function automatic bit apply_command(shape_cmd_type cmd, output placement_type res);
      int o, c;
      res = '0;
      o = cmd.oi;
      case (cmd.op)
         blsp_pkg::OP_CLEAR: begin
            foreach (occ[y, x]) occ[y][x] = 0;
         end
         blsp_pkg::OP_START: new_piece();
         blsp_pkg::OP_LOAD: begin
            if (o < blsp_pkg::MaxOrient && cell_cnt[o] < blsp_pkg::MaxCells) begin
               c = cell_cnt[o];
               cell_x[o][c] = cmd.cx;
               cell_y[o][c] = cmd.cy;
               cell_cnt[o] = c + 1;
               if (cmd.cx > box_x[o]) box_x[o] = cmd.cx;
               if (cmd.cy > box_y[o]) box_y[o] = cmd.cy;
               tag_rot[o] = cmd.rot;
               tag_flip[o] = cmd.flip;
            end
         end
         default: begin
            res = place_piece();
            return 1;
         end
      endcase
      return 0;
   endfunction

   function automatic shape_cmd_type pack_cmd(logic [1:0] op, int oi, int cx, int cy,
                                              int rot, int flip);
      shape_cmd_type cmd;
      cmd = '0;
      cmd.op = op; cmd.oi = 3'(oi); cmd.cx = 6'(cx); cmd.cy = 6'(cy);
      cmd.rot = 2'(rot); cmd.flip = 1'(flip);
      return cmd;
   endfunction

   function automatic int draw_gap(bit calm);
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   // typed: queue the given placement instead of the predicted one
   task automatic send_cmd(shape_cmd_type cmd, bit typed = 0, placement_type want = '0);
      int gap;
      placement_type res;
      gap = draw_gap(calm_send);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (apply_command(cmd, res))
         expected_placements = {expected_placements, (typed ? want : res)};
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);   // clear sweep may still be running
   endtask

   task automatic csr_write(logic idx, int value);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * idx); csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
      if (idx == blsp_pkg::REG_WIDTH) grid_w = value & 'h7f;
      else grid_h = value & 'h7f;
   endtask

   // one piece: an occasional clear, start, loads of a few orientations, some place commands, then at times a stray one
   task automatic piece_sequence();
      int n_orient, n_cells, span, o;
      if ($urandom_range(0, 7) == 0) send_cmd(pack_cmd(blsp_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
      send_cmd(pack_cmd(blsp_pkg::OP_START, $urandom, $urandom, $urandom, $urandom,
                        $urandom));
      n_orient = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
      for (int k = 0; k < n_orient; k++) begin
         o = $urandom_range(0, blsp_pkg::MaxOrient - 1);
         n_cells = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 4);
         span = ($urandom_range(0, 9) == 0) ? 63 : 3;
         for (int c = 0; c < n_cells; c++)
            send_cmd(pack_cmd(blsp_pkg::OP_LOAD, o, $urandom_range(0, span),
                              $urandom_range(0, span),
                              $urandom_range(0, 3), $urandom_range(0, 1)));
      end
      repeat ($urandom_range(1, 4)) send_cmd(pack_cmd(blsp_pkg::OP_PLACE, $urandom, $urandom,
                                                      $urandom, $urandom, $urandom));
      if ($urandom_range(0, 5) == 0)   // stray transaction
         send_cmd(pack_cmd(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom));
   endtask

   // response side
   initial begin
      int stall;
      placement_type got, want;
      forever begin
         stall = draw_gap(calm_recv);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         got = rsp_tdata;
         if (expected_placements.size() == 0) begin
            report_mismatch("unexpected result", 0, 1);
         end else begin
            want = expected_placements.pop_front();
            if (got.placed !== want.placed) report_mismatch("placed", want.placed, got.placed);
            if (got.px !== want.px) report_mismatch("place_x", want.px, got.px);
            if (got.py !== want.py) report_mismatch("place_y", want.py, got.py);
            if (got.rot !== want.rot) report_mismatch("rotation", want.rot, got.rot);
            if (got.flip !== want.flip) report_mismatch("flip", want.flip, got.flip);
         end
      end
   end

   initial begin
      directed_row_type dir_rows [$];
      int grid_ext [6][2];
      int n_items;
      placement_type ok00, ok10;
      ok00 = '0; ok00.placed = 1; ok00.rot = 1;
      ok10 = ok00; ok10.px = 1;
      grid_ext = '{'{1, 1}, '{0, 5}, '{5, 0}, '{127, 127}, '{64, 2}, '{2, 64}};
      // empty piece fails, last tags win, repeated cell, far corner cell, repeated place
      dir_rows = '{
         '{blsp_pkg::OP_PLACE, 0, 0, 0, 0, 0, 1, placement_type'(0)},
         '{blsp_pkg::OP_START, 7, 63, 63, 3, 1, 0, placement_type'(0)},
         '{blsp_pkg::OP_LOAD, 0, 0, 0, 3, 1, 0, placement_type'(0)},
         '{blsp_pkg::OP_LOAD, 0, 0, 0, 1, 0, 0, placement_type'(0)},
         '{blsp_pkg::OP_PLACE, 0, 0, 0, 0, 0, 1, ok00},
         '{blsp_pkg::OP_PLACE, 0, 0, 0, 0, 0, 1, ok10},
         '{blsp_pkg::OP_LOAD, 7, 63, 63, 3, 1, 0, placement_type'(0)},
         '{blsp_pkg::OP_PLACE, 0, 0, 0, 0, 0, 0, placement_type'(0)},
         '{blsp_pkg::OP_PLACE, 0, 0, 0, 0, 0, 0, placement_type'(0)},
         '{blsp_pkg::OP_LOAD, 3, 2, 1, 2, 1, 0, placement_type'(0)},
         '{blsp_pkg::OP_LOAD, 3, 0, 2, 0, 0, 0, placement_type'(0)},
         '{blsp_pkg::OP_PLACE, 0, 0, 0, 0, 0, 0, placement_type'(0)},
         '{blsp_pkg::OP_CLEAR, 5, 17, 40, 2, 1, 0, placement_type'(0)},
         '{blsp_pkg::OP_PLACE, 0, 0, 0, 0, 0, 0, placement_type'(0)},
         '{blsp_pkg::OP_START, 0, 0, 0, 0, 0, 0, placement_type'(0)},
         '{blsp_pkg::OP_PLACE, 0, 0, 0, 0, 0, 1, placement_type'(0)},
         '{blsp_pkg::OP_LOAD, 5, 0, 0, 3, 1, 0, placement_type'(0)},
         '{blsp_pkg::OP_PLACE, 0, 0, 0, 0, 0, 0, placement_type'(0)},
         '{blsp_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, placement_type'(0)}};

      reset <= 1'b1;
      req_tvalid <= 1'b0; req_tdata <= '0;
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      csr_paddr <= '0; csr_pwdata <= '0;
      calm_send = 0; calm_recv = 0;
      new_piece();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_cmd(pack_cmd(dir_rows[i].op, dir_rows[i].oi, dir_rows[i].cx, dir_rows[i].cy,
                           dir_rows[i].rot, dir_rows[i].flip),
                  dir_rows[i].typed, dir_rows[i].want);

      for (int phase = 0; items_sent < 1120; phase++) begin
         wait_idle();
         req_tvalid <= 1'b0;
         if (phase < 6) begin
            csr_write(blsp_pkg::REG_WIDTH, grid_ext[phase][0]);
            csr_write(blsp_pkg::REG_HEIGHT, grid_ext[phase][1]);
         end else begin
            csr_write(blsp_pkg::REG_WIDTH, $urandom_range(1, 12));
            csr_write(blsp_pkg::REG_HEIGHT, $urandom_range(1, 12));
         end
         calm_send = ($urandom_range(0, 3) == 0);
         calm_recv = ($urandom_range(0, 3) == 0);
         n_items = items_sent + $urandom_range(40, 70);
         while (items_sent < n_items) piece_sequence();
      end

      wait_idle();
      req_tvalid <= 1'b0;
      if (fail_count == 0)
         $display("bottom_left_shape_placer test passed");
      else
         $display("bottom_left_shape_placer test failed");
      $finish;
   end
endmodule
